// ===== rtl/fha_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and block table entry type for the heap allocator
// no dependencies

package fha_pkg;

    localparam int HEAP_MAX_BYTES = 65536;
    localparam int MAX_BLOCKS     = 1024;
    localparam int HEADER_BYTES   = 17;
    localparam int MIN_CAPACITY   = 24;

    localparam int SLOT_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = SLOT_W + 1;
    localparam int BYTE_W = 17;
    localparam int OFS_W  = 16;
    localparam int CFG_W  = 2;

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_FREE    = 2'd1;
    localparam logic [1:0] REQ_INIT    = 2'd2;
    localparam logic [1:0] REQ_RELEASE = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_MEM    = 2'd1;
    localparam logic [1:0] ST_NOT_READY = 2'd2;
    localparam logic [1:0] ST_BAD_ADDR  = 2'd3;

    localparam logic [CFG_W-1:0] CFG_PAGE   = 2'd0;
    localparam logic [CFG_W-1:0] CFG_REGION = 2'd1;
    localparam logic [CFG_W-1:0] CFG_LIMIT  = 2'd2;

    typedef struct packed {
        logic [OFS_W-1:0]  start;
        logic [BYTE_W-1:0] cap;
        logic              free;
        logic              last;
        logic [SLOT_W-1:0] next;
    } t_entry;

endpackage

// ===== rtl/fha_if.sv =====
`timescale 1ns / 1ps
// request, response and configuration channels of the heap allocator
// depends on fha_pkg

interface fha_req_if import fha_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       req_type;
    logic [OFS_W-1:0] size;
    logic [OFS_W-1:0] addr;
    modport source (output valid, req_type, size, addr, input ready);
    modport sink   (input valid, req_type, size, addr, output ready);
endinterface

interface fha_resp_if import fha_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [OFS_W-1:0] result_addr;
    modport source (output valid, status, result_addr, input ready);
    modport sink   (input valid, status, result_addr, output ready);
endinterface

interface fha_cfg_if import fha_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CFG_W-1:0]  index;
    logic [BYTE_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
// first-fit heap allocator: linked block table in one memory, a free-slot stack,
// a bit-serial remainder unit for page rounding; depends on fha_pkg and fha_if
// alloc/free walk the table, fetching then examining each entry; free successors are merged
// growth reruns the remainder unit and a second walk; init runs it too, release answers from idle
// throughput: one request at a time, the next is taken after the response leaves
// reset: synchronous active-low, clears control state, heap not ready, registers to defaults
module first_fit_heap_allocator import fha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fha_req_if.sink     i_req,
    fha_resp_if.source  o_resp,
    fha_cfg_if.sink     i_cfg
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_DIV    = 14'b00000000000010,
        S_INIT   = 14'b00000000000100,
        S_FETCH  = 14'b00000000001000,
        S_EXAM   = 14'b00000000010000,
        S_MFETCH = 14'b00000000100000,
        S_MEXAM  = 14'b00000001000000,
        S_DECIDE = 14'b00000010000000,
        S_SPLIT  = 14'b00000100000000,
        S_NOFIT  = 14'b00001000000000,
        S_GROW   = 14'b00010000000000,
        S_GFETCH = 14'b00100000000000,
        S_GEXAM  = 14'b01000000000000,
        S_GLINK  = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    logic [BYTE_W-1:0] r_page, r_region_min, r_limit;

    t_entry              r_mem [MAX_BLOCKS];
    logic [SLOT_W-1:0]   r_stk [MAX_BLOCKS];

    t_entry              r_rd, r_e, n_e;
    logic [SLOT_W-1:0]   r_cur, n_cur, r_tail, n_tail, r_new, n_new, r_top;
    logic [CNT_W-1:0]    r_count, n_count, r_sp, n_sp, r_bump, n_bump;
    logic [BYTE_W-1:0]   r_heap, n_heap, r_query, n_query, r_grow, n_grow;
    logic [BYTE_W-1:0]   r_need, n_need, r_rem, n_rem, r_num, n_num;
    logic [4:0]          r_dcnt, n_dcnt;
    logic                r_ready, n_ready, r_pass, n_pass, r_is_free, n_is_free;
    logic                r_div_grow, n_div_grow, r_busy_out, n_busy_out;
    logic [1:0]          r_status, n_status;
    logic [OFS_W-1:0]    r_addr, n_addr, r_res, n_res;

    logic                w_we, w_push;
    logic [SLOT_W-1:0]   w_waddr, w_raddr, w_slot, w_push_val;
    t_entry              w_wdata;
    logic [BYTE_W-1:0]   w_pg, w_lim;
    logic [BYTE_W:0]     w_t, w_rsz, w_region;
    logic [CNT_W-1:0]    w_sp_m1;
    logic [BYTE_W:0]     w_split_need;
    logic [BYTE_W+1:0]   w_heap_sum;

    assign w_pg  = (r_page == '0) ? BYTE_W'(1) : r_page;
    assign w_lim = (r_limit > BYTE_W'(HEAP_MAX_BYTES)) ? BYTE_W'(HEAP_MAX_BYTES) : r_limit;
    assign w_t   = {r_rem, r_num[BYTE_W-1]};
    assign w_rsz = (r_rem == '0) ? {1'b0, r_need}
                 : {1'b0, r_need} + {1'b0, w_pg} - {1'b0, r_rem};
    assign w_region = (w_rsz < {1'b0, r_region_min}) ? {1'b0, r_region_min} : w_rsz;
    assign w_slot   = (r_sp != '0) ? r_top : r_bump[SLOT_W-1:0];
    assign w_split_need = {1'b0, r_query} + (BYTE_W+1)'(HEADER_BYTES + MIN_CAPACITY);
    assign w_heap_sum   = {2'b0, r_heap} + {1'b0, w_region};

    assign i_req.ready        = (r_state == S_IDLE) && !r_busy_out;
    assign i_cfg.ready        = 1'b1;
    assign o_resp.valid       = r_busy_out;
    assign o_resp.status      = r_status;
    assign o_resp.result_addr = r_res;

    always_comb begin
        case (r_state)
            S_MFETCH: w_raddr = r_e.next;
            S_GFETCH: w_raddr = r_tail;
            default:  w_raddr = r_cur;
        endcase
    end

    always_comb begin
        n_state = r_state;   n_e = r_e;         n_cur = r_cur;     n_tail = r_tail;
        n_new = r_new;       n_count = r_count; n_sp = r_sp;       n_bump = r_bump;
        n_heap = r_heap;     n_query = r_query; n_grow = r_grow;   n_need = r_need;
        n_rem = r_rem;       n_num = r_num;     n_dcnt = r_dcnt;   n_ready = r_ready;
        n_pass = r_pass;     n_is_free = r_is_free;  n_div_grow = r_div_grow;
        n_busy_out = r_busy_out;  n_status = r_status;  n_addr = r_addr;  n_res = r_res;
        w_we = 1'b0;  w_waddr = r_cur;  w_wdata = r_e;
        w_push = 1'b0;  w_push_val = r_e.next;

        if (r_busy_out && o_resp.ready) begin
            n_busy_out = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_status = ST_OK;
                    n_res    = '0;
                    n_addr   = i_req.addr;
                    n_pass   = 1'b0;
                    n_cur    = '0;
                    case (i_req.req_type)
                        REQ_ALLOC: begin
                            n_is_free = 1'b0;
                            n_query = (i_req.size < OFS_W'(MIN_CAPACITY))
                                    ? BYTE_W'(MIN_CAPACITY) : {1'b0, i_req.size};
                            if (!r_ready) begin
                                n_status   = ST_NOT_READY;
                                n_busy_out = 1'b1;
                            end else begin
                                n_state = S_FETCH;
                            end
                        end
                        REQ_FREE: begin
                            n_is_free = 1'b1;
                            if (i_req.addr == '0) begin
                                n_busy_out = 1'b1;
                            end else if (!r_ready) begin
                                n_status   = ST_NOT_READY;
                                n_busy_out = 1'b1;
                            end else begin
                                n_state = S_FETCH;
                            end
                        end
                        REQ_INIT: begin
                            n_need     = {1'b0, i_req.size} + BYTE_W'(HEADER_BYTES);
                            n_num      = {1'b0, i_req.size} + BYTE_W'(HEADER_BYTES);
                            n_rem      = '0;
                            n_dcnt     = '0;
                            n_div_grow = 1'b0;
                            n_state    = S_DIV;
                        end
                        default: begin
                            n_count    = '0;
                            n_heap     = '0;
                            n_ready    = 1'b0;
                            n_busy_out = 1'b1;
                        end
                    endcase
                end
            end
            S_DIV: begin
                n_rem = (w_t >= {1'b0, w_pg}) ? BYTE_W'(w_t - {1'b0, w_pg}) : w_t[BYTE_W-1:0];
                n_num = r_num << 1;
                n_dcnt = r_dcnt + 5'd1;
                if (r_dcnt == 5'(BYTE_W - 1)) begin
                    n_state = r_div_grow ? S_GROW : S_INIT;
                end
            end
            S_INIT: begin
                if (w_region > {1'b0, w_lim}) begin
                    n_status = ST_NO_MEM;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = '0;
                    w_wdata = '{start: '0, cap: BYTE_W'(w_region - (BYTE_W+1)'(HEADER_BYTES)),
                                free: 1'b1, last: 1'b1, next: '0};
                    n_tail  = '0;
                    n_bump  = CNT_W'(1);
                    n_sp    = '0;
                    n_count = CNT_W'(1);
                    n_heap  = w_region[BYTE_W-1:0];
                    n_ready = 1'b1;
                end
                n_busy_out = 1'b1;
                n_state    = S_IDLE;
            end
            S_FETCH: begin
                n_state = S_EXAM;
            end
            S_EXAM: begin
                n_e = r_rd;
                if (r_is_free) begin
                    if (({1'b0, r_rd.start} + BYTE_W'(HEADER_BYTES)) == {1'b0, r_addr}) begin
                        n_e.free = 1'b1;
                        n_state  = r_rd.last ? S_DECIDE : S_MFETCH;
                    end else if (r_rd.last) begin
                        n_status   = ST_BAD_ADDR;
                        n_busy_out = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_cur   = r_rd.next;
                        n_state = S_FETCH;
                    end
                end else if (r_rd.free) begin
                    n_state = r_rd.last ? S_DECIDE : S_MFETCH;
                end else if (r_rd.last) begin
                    n_state = S_NOFIT;
                end else begin
                    n_cur   = r_rd.next;
                    n_state = S_FETCH;
                end
            end
            S_MFETCH: begin
                n_state = S_MEXAM;
            end
            S_MEXAM: begin
                if (r_rd.free) begin
                    n_e.cap    = r_e.cap + BYTE_W'(HEADER_BYTES) + r_rd.cap;
                    n_e.last   = r_rd.last;
                    n_e.next   = r_rd.next;
                    w_push     = 1'b1;
                    w_push_val = r_e.next;
                    n_sp       = r_sp + CNT_W'(1);
                    n_count    = r_count - CNT_W'(1);
                    if (r_rd.last) begin
                        n_tail = r_cur;
                    end
                    n_state = r_rd.last ? S_DECIDE : S_MFETCH;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                w_we    = 1'b1;
                w_waddr = r_cur;
                w_wdata = r_e;
                if (r_is_free) begin
                    n_busy_out = 1'b1;
                    n_state    = S_IDLE;
                end else if (r_e.cap >= r_query) begin
                    n_res = r_e.start + OFS_W'(HEADER_BYTES);
                    if ({1'b0, r_e.cap} >= w_split_need && r_count < CNT_W'(MAX_BLOCKS)) begin
                        w_waddr = w_slot;
                        w_wdata = '{start: r_e.start + OFS_W'(HEADER_BYTES) + r_query[OFS_W-1:0],
                                    cap: r_e.cap - r_query - BYTE_W'(HEADER_BYTES),
                                    free: 1'b1, last: r_e.last, next: r_e.next};
                        if (r_sp != '0) begin
                            n_sp = r_sp - CNT_W'(1);
                        end else begin
                            n_bump = r_bump + CNT_W'(1);
                        end
                        if (r_e.last) begin
                            n_tail = w_slot;
                        end
                        n_e.cap  = r_query;
                        n_e.free = 1'b0;
                        n_e.last = 1'b0;
                        n_e.next = w_slot;
                        n_count  = r_count + CNT_W'(1);
                        n_state  = S_SPLIT;
                    end else begin
                        w_wdata.free = 1'b0;
                        n_busy_out   = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else if (r_e.last) begin
                    n_state = S_NOFIT;
                end else begin
                    n_cur   = r_e.next;
                    n_state = S_FETCH;
                end
            end
            S_SPLIT: begin
                w_we       = 1'b1;
                w_waddr    = r_cur;
                w_wdata    = r_e;
                n_busy_out = 1'b1;
                n_state    = S_IDLE;
            end
            S_NOFIT: begin
                if (r_pass) begin
                    n_status   = ST_NO_MEM;
                    n_busy_out = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_need     = r_query + BYTE_W'(HEADER_BYTES);
                    n_num      = r_query + BYTE_W'(HEADER_BYTES);
                    n_rem      = '0;
                    n_dcnt     = '0;
                    n_div_grow = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_GROW: begin
                if (w_heap_sum > {2'b0, w_lim}) begin
                    n_status   = ST_NO_MEM;
                    n_busy_out = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_grow  = w_region[BYTE_W-1:0];
                    n_state = S_GFETCH;
                end
            end
            S_GFETCH: begin
                n_state = S_GEXAM;
            end
            S_GEXAM: begin
                n_e = r_rd;
                if (r_rd.free) begin
                    w_we        = 1'b1;
                    w_waddr     = r_tail;
                    w_wdata     = r_rd;
                    w_wdata.cap = r_rd.cap + r_grow;
                    n_heap      = r_heap + r_grow;
                    n_pass      = 1'b1;
                    n_cur       = '0;
                    n_state     = S_FETCH;
                end else if (r_count >= CNT_W'(MAX_BLOCKS)) begin
                    n_status   = ST_NO_MEM;
                    n_busy_out = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = w_slot;
                    w_wdata = '{start: r_heap[OFS_W-1:0], cap: r_grow - BYTE_W'(HEADER_BYTES),
                                free: 1'b1, last: 1'b1, next: '0};
                    if (r_sp != '0) begin
                        n_sp = r_sp - CNT_W'(1);
                    end else begin
                        n_bump = r_bump + CNT_W'(1);
                    end
                    n_new    = w_slot;
                    n_e.last = 1'b0;
                    n_e.next = w_slot;
                    n_state  = S_GLINK;
                end
            end
            S_GLINK: begin
                w_we    = 1'b1;
                w_waddr = r_tail;
                w_wdata = r_e;
                n_tail  = r_new;
                n_count = r_count + CNT_W'(1);
                n_heap  = r_heap + r_grow;
                n_pass  = 1'b1;
                n_cur   = '0;
                n_state = S_FETCH;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_sp_m1 = n_sp - CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stk[r_sp[SLOT_W-1:0]] <= w_push_val;
            r_top <= w_push_val;
        end else begin
            r_top <= r_stk[w_sp_m1[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page       <= BYTE_W'(4096);
            r_region_min <= BYTE_W'(8192);
            r_limit      <= BYTE_W'(65536);
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_PAGE:   r_page       <= i_cfg.data;
                CFG_REGION: r_region_min <= i_cfg.data;
                CFG_LIMIT:  r_limit      <= i_cfg.data;
                default:    r_page       <= r_page;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_heap     <= '0;
            r_ready    <= 1'b0;
            r_busy_out <= 1'b0;
            r_sp       <= '0;
            r_bump     <= '0;
            r_tail     <= '0;
            r_pass     <= 1'b0;
            r_dcnt     <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_heap     <= n_heap;
            r_ready    <= n_ready;
            r_busy_out <= n_busy_out;
            r_sp       <= n_sp;
            r_bump     <= n_bump;
            r_tail     <= n_tail;
            r_pass     <= n_pass;
            r_dcnt     <= n_dcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e        <= n_e;
        r_cur      <= n_cur;
        r_new      <= n_new;
        r_query    <= n_query;
        r_grow     <= n_grow;
        r_need     <= n_need;
        r_rem      <= n_rem;
        r_num      <= n_num;
        r_is_free  <= n_is_free;
        r_div_grow <= n_div_grow;
        r_status   <= n_status;
        r_addr     <= n_addr;
        r_res      <= n_res;
    end

endmodule
